// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the colour expansion blit RTL.
// Depends on nothing; included inside module bodies that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBCE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("mbce assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MBCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("mbce assertion failed");

`endif

// ----- rtl/mbce_pkg.sv -----
// Shared types, constants and helper functions for the colour expansion blit.
// Depends on nothing; imported by every module of the block.
package mbce_pkg;

    // Widest row in source bits; the end bit is clamped below it.
    localparam int MAX_ROW_BITS   = 512;
    localparam int END_LIM        = (MAX_ROW_BITS - 1 > 511) ? 511 : MAX_ROW_BITS - 1;
    // Default depth of the job queue between front and back.
    localparam int FIFO_DEPTH_DEF = 4;
    localparam int CFG_IDX_W      = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEST_BASE   = 3'd0,
        CFG_DEST_STRIDE = 3'd1,
        CFG_FIRST_BIT   = 3'd2,
        CFG_END_BIT     = 3'd3,
        CFG_PIXEL_BYTES = 3'd4,
        CFG_FILL_COLOUR = 3'd5,
        CFG_ROW_COUNT   = 3'd6
    } t_cfg_idx;

    // Current configuration register contents.
    typedef struct packed {
        logic [31:0] dest_base;
        logic [31:0] dest_stride;
        logic [2:0]  first_bit;
        logic [8:0]  end_bit;
        logic [2:0]  pixel_bytes;
        logic [31:0] fill_colour;
        logic [11:0] row_count;
    } t_cfg;

    // One classified source byte handed from front to back.
    typedef struct packed {
        logic [7:0]  bits;
        logic [31:0] addr;
        logic        op_end;
    } t_job;

    // Pixel size with out-of-range codes folded onto 1 and 4.
    function automatic logic [2:0] eff_size(input logic [2:0] p);
        logic [2:0] s;
        if (p == 3'd0) begin
            s = 3'd1;
        end else if (p > 3'd4) begin
            s = 3'd4;
        end else begin
            s = p;
        end
        return s;
    endfunction

    // End bit clamped to the widest supported row.
    function automatic logic [8:0] eff_end(input logic [8:0] e);
        return (e > 9'(END_LIM)) ? 9'(END_LIM) : e;
    endfunction

    // Pixel bytes in ascending address order for the given size.
    function automatic logic [31:0] pixel_data(input logic [31:0] c, input logic [2:0] size);
        logic [31:0] d;
        case (size)
            3'd1:    d = {24'd0, c[7:0]};
            3'd2:    d = {16'd0, c[7:0], c[15:8]};
            3'd3:    d = {8'd0, c[7:0], c[15:8], c[23:16]};
            default: d = c;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/mono_bitmap_colour_expand.sv -----
// Top level of the monochrome colour expansion blit: configuration registers,
// front end, job queue and write sequencer. Depends on mbce_pkg and the submodules.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+--------------------------------
//  input   | in        | i_in_valid / o_in_ready   | i_bitmap_byte
//  output  | out       | o_out_valid / i_out_ready | o_write_address, o_write_data,
//          |           |                           | o_write_count, o_last_of_byte,
//          |           |                           | o_operation_done
//  config  | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// The front end takes one source byte per clock while the job queue has room.
// The write sequencer issues one pixel write per clock unless the output stalls,
// one write for each drawn bit of a byte; the single write port sets the rate.
// A byte that draws nothing is dropped by the front end and produces no write.
// Reset is synchronous and needs no clearing pass; configuration writes are taken every cycle.
// An output stall fills the queue and then holds o_in_ready low.
module mono_bitmap_colour_expand #(
    parameter int FIFO_DEPTH = mbce_pkg::FIFO_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [7:0]                     i_bitmap_byte,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [31:0]                    o_write_address,
    output logic [31:0]                    o_write_data,
    output logic [2:0]                     o_write_count,
    output logic                           o_last_of_byte,
    output logic                           o_operation_done,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mbce_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import mbce_pkg::*;

    t_cfg r_cfg;
    logic cfg_write;
    logic restart;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_job front_job;
    t_job queue_job;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid;

    // Configuration registers; any write to a listed register restarts the operation.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dest_base   <= 32'd0;
            r_cfg.dest_stride <= 32'd0;
            r_cfg.first_bit   <= 3'd0;
            r_cfg.end_bit     <= 9'd7;
            r_cfg.pixel_bytes <= 3'd1;
            r_cfg.fill_colour <= 32'd0;
            r_cfg.row_count   <= 12'd1;
        end else if (cfg_write) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEST_BASE:   r_cfg.dest_base   <= i_cfg_data;
                CFG_DEST_STRIDE: r_cfg.dest_stride <= i_cfg_data;
                CFG_FIRST_BIT:   r_cfg.first_bit   <= i_cfg_data[2:0];
                CFG_END_BIT:     r_cfg.end_bit     <= i_cfg_data[8:0];
                CFG_PIXEL_BYTES: r_cfg.pixel_bytes <= i_cfg_data[2:0];
                CFG_FILL_COLOUR: r_cfg.fill_colour <= i_cfg_data;
                CFG_ROW_COUNT:   r_cfg.row_count   <= i_cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Restart request for the front end on a write to a listed register.
    always_comb begin
        restart = 1'b0;
        if (cfg_write) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_DEST_BASE, CFG_DEST_STRIDE, CFG_FIRST_BIT, CFG_END_BIT,
                CFG_PIXEL_BYTES, CFG_FILL_COLOUR, CFG_ROW_COUNT: restart = 1'b1;
                default: restart = 1'b0;
            endcase
        end
    end

    mbce_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_restart     (restart),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_bitmap_byte (i_bitmap_byte),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (front_job)
    );

    mbce_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_job   (queue_job)
    );

    mbce_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_q_empty        (q_empty),
        .i_job            (queue_job),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_write_address  (o_write_address),
        .o_write_data     (o_write_data),
        .o_write_count    (o_write_count),
        .o_last_of_byte   (o_last_of_byte),
        .o_operation_done (o_operation_done)
    );

endmodule

// ----- rtl/mbce_front.sv -----
// Front end: accepts source bytes, masks row edges and tracks row position.
// Depends on mbce_pkg; feeds classified bytes into the job queue.
module mbce_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbce_pkg::t_cfg i_cfg,
    input  logic           i_restart,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [7:0]     i_bitmap_byte,
    input  logic           i_q_full,
    output logic           o_push,
    output mbce_pkg::t_job o_job
);
    import mbce_pkg::*;

    logic        r_fresh;
    logic [5:0]  r_bir;
    logic [11:0] r_rows_done;
    logic [31:0] r_row_start;
    logic [31:0] r_byte_addr;

    logic [8:0]  end_eff;
    logic [5:0]  last_byte;
    logic [2:0]  size;
    logic [11:0] rows;
    logic        bir_wrap;
    logic [5:0]  bir;
    logic [31:0] row_start_cur;
    logic [31:0] addr_cur;
    logic [7:0]  mask_first;
    logic [7:0]  mask_last;
    logic [7:0]  bits;
    logic        row_end;
    logic        op_end;
    logic        accept;

    // Row geometry and edge masks for the byte on the input.
    always_comb begin
        end_eff       = eff_end(i_cfg.end_bit);
        last_byte     = end_eff[8:3];
        size          = eff_size(i_cfg.pixel_bytes);
        rows          = (i_cfg.row_count == 12'd0) ? 12'd1 : i_cfg.row_count;
        bir_wrap      = r_bir > last_byte;
        bir           = bir_wrap ? 6'd0 : r_bir;
        row_start_cur = r_fresh ? i_cfg.dest_base : r_row_start;
        addr_cur      = (r_fresh || bir_wrap) ? row_start_cur : r_byte_addr;
        mask_first    = (bir == 6'd0) ? (8'hFF >> i_cfg.first_bit) : 8'hFF;
        mask_last     = (bir == last_byte) ? 8'(16'hFF00 >> end_eff[2:0]) : 8'hFF;
        bits          = i_bitmap_byte & mask_first & mask_last;
        row_end       = bir == last_byte;
        op_end        = row_end && (({1'b0, r_rows_done} + 13'd1) >= {1'b0, rows});
    end

    // Handshake and queue push; bytes with nothing to draw are dropped here.
    assign o_in_ready   = !i_q_full;
    assign accept       = i_in_valid && !i_q_full;
    assign o_push       = accept && (bits != 8'd0);
    assign o_job.bits   = bits;
    assign o_job.addr   = addr_cur;
    assign o_job.op_end = op_end;

    // Row position control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_fresh     <= 1'b1;
            r_bir       <= 6'd0;
            r_rows_done <= 12'd0;
        end else if (accept) begin
            if (row_end) begin
                r_bir <= 6'd0;
                if (op_end) begin
                    r_fresh     <= 1'b1;
                    r_rows_done <= 12'd0;
                end else begin
                    r_fresh     <= 1'b0;
                    r_rows_done <= r_rows_done + 12'd1;
                end
            end else begin
                r_fresh <= 1'b0;
                r_bir   <= bir + 6'd1;
            end
        end
    end

    // Destination addresses of the current row and the next byte.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            if (row_end) begin
                r_row_start <= row_start_cur + i_cfg.dest_stride;
                r_byte_addr <= row_start_cur + i_cfg.dest_stride;
            end else begin
                r_row_start <= row_start_cur;
                r_byte_addr <= addr_cur + 32'({size, 3'b000});
            end
        end
    end

endmodule

// ----- rtl/mbce_fifo.sv -----
// Short job queue between the front end and the write sequencer.
// Depends on mbce_pkg for the job type.
module mbce_fifo #(
    parameter int DEPTH = mbce_pkg::FIFO_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mbce_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output mbce_pkg::t_job o_job
);
    import mbce_pkg::*;

    `include "assert_macros.svh"

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_job   = r_mem[r_rd_ptr];

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    `MBCE_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, o_full, !i_push)
    `MBCE_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, o_empty, !i_pop)

endmodule

// ----- rtl/mbce_back.sv -----
// Back end: expands one queued byte into pixel writes, one per unstalled clock.
// Depends on mbce_pkg; drives the registered output channel.
module mbce_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mbce_pkg::t_cfg i_cfg,
    input  logic           i_q_empty,
    input  mbce_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [31:0]    o_write_address,
    output logic [31:0]    o_write_data,
    output logic [2:0]     o_write_count,
    output logic           o_last_of_byte,
    output logic           o_operation_done
);
    import mbce_pkg::*;

    `include "assert_macros.svh"

    logic        r_busy;
    logic [7:0]  r_bits;
    logic [31:0] r_base;
    logic        r_op;
    logic        r_out_valid;
    logic [31:0] r_addr;
    logic [31:0] r_data;
    logic [2:0]  r_count;
    logic        r_last;
    logic        r_done;

    logic [2:0]  size;
    logic [2:0]  x;
    logic        found;
    logic [7:0]  bits_left;
    logic        out_free;
    logic        issue;
    logic        finish;
    logic [5:0]  offset;

    // Pick the leftmost remaining pixel and its address.
    always_comb begin
        size  = eff_size(i_cfg.pixel_bytes);
        x     = 3'd0;
        found = 1'b0;
        for (int i = 0; i < 8; i++) begin
            if (!found && r_bits[7 - i]) begin
                x     = 3'(i);
                found = 1'b1;
            end
        end
        bits_left = r_bits & ~(8'h80 >> x);
        offset    = 6'(x) * 6'(size);
        out_free  = !r_out_valid || i_out_ready;
        issue     = r_busy && out_free;
        finish    = issue && (bits_left == 8'd0);
    end

    assign o_pop = !i_q_empty && (!r_busy || finish);

    // Job register: load from the queue, then clear one bit per write.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
        end else if (finish) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bits <= i_job.bits;
            r_base <= i_job.addr;
            r_op   <= i_job.op_end;
        end else if (issue) begin
            r_bits <= bits_left;
        end
    end

    // Output register holding one write transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (issue) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_addr  <= r_base + 32'(offset);
            r_data  <= pixel_data(i_cfg.fill_colour, size);
            r_count <= size;
            r_last  <= bits_left == 8'd0;
            r_done  <= r_op;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_write_address  = r_addr;
    assign o_write_data     = r_data;
    assign o_write_count    = r_count;
    assign o_last_of_byte   = r_last;
    assign o_operation_done = r_done;

    `MBCE_ASSERT_IMPL(a_busy_has_bits, i_clk, i_rst_n, r_busy, r_bits != 8'd0)
    `MBCE_ASSERT_NEXT(a_issue_shows, i_clk, i_rst_n, issue, r_out_valid)

endmodule

// ----- bench/tb_mono_bitmap_colour_expand.sv -----
// Self-checking testbench for the monochrome colour expansion blit.
// Depends on mbce_pkg and mono_bitmap_colour_expand; it predicts every pixel write
// in-line and checks each output transaction against the oldest expected write.
module tb_mono_bitmap_colour_expand;
    import mbce_pkg::*;

    localparam int LIMIT_CYCLES  = 300000;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 280;
    localparam int QUIET_ITEMS   = 50;
    localparam int MAX_PRINTED   = 200;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    // One predicted pixel write.
    typedef struct {
        logic [31:0] addr;
        logic [31:0] data;
        logic [2:0]  count;
        logic        last_flag;
        logic        done;
    } t_pixel_write;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_bitmap_byte;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [31:0]          o_write_address;
    logic [31:0]          o_write_data;
    logic [2:0]           o_write_count;
    logic                 o_last_of_byte;
    logic                 o_operation_done;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [31:0]          i_cfg_data;

    // Register copies and blit position kept by the predictor.
    logic [31:0] reg_dest_base;
    logic [31:0] reg_dest_stride;
    logic [2:0]  reg_first_bit;
    logic [8:0]  reg_end_bit;
    logic [2:0]  reg_pixel_bytes;
    logic [31:0] reg_fill_colour;
    logic [11:0] reg_row_count;
    logic [31:0] row_start;
    logic [5:0]  row_pos;
    logic [11:0] rows_done;

    t_pixel_write pending_writes[$];
    int           error_count;
    int           bytes_sent;
    int           writes_seen;
    int           cfg_writes;
    int           cycle_count;
    int           input_gap_odds;
    logic         quiet;

    mono_bitmap_colour_expand i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_bitmap_byte    (i_bitmap_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_write_address  (o_write_address),
        .o_write_data     (o_write_data),
        .o_write_count    (o_write_count),
        .o_last_of_byte   (o_last_of_byte),
        .o_operation_done (o_operation_done),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    // Free-running clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // A stuck run ends here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_mono_bitmap_colour_expand NOT OK");
            $finish;
        end
    end

    // Count a mismatch and print one line for each of the first MAX_PRINTED.
    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Any write to a listed register returns the blit to the first row.
    function automatic void restart_operation();
        row_start = reg_dest_base;
        row_pos   = '0;
        rows_done = '0;
    endfunction

    function automatic void reset_registers();
        reg_dest_base   = '0;
        reg_dest_stride = '0;
        reg_first_bit   = '0;
        reg_end_bit     = 9'd7;
        reg_pixel_bytes = 3'd1;
        reg_fill_colour = '0;
        reg_row_count   = 12'd1;
        restart_operation();
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [31:0] value);
        logic known;
        known = 1'b1;
        case (idx)
            CFG_DEST_BASE:   reg_dest_base   = value;
            CFG_DEST_STRIDE: reg_dest_stride = value;
            CFG_FIRST_BIT:   reg_first_bit   = value[2:0];
            CFG_END_BIT:     reg_end_bit     = value[8:0];
            CFG_PIXEL_BYTES: reg_pixel_bytes = value[2:0];
            CFG_FILL_COLOUR: reg_fill_colour = value;
            CFG_ROW_COUNT:   reg_row_count   = value[11:0];
            default:         known = 1'b0;
        endcase
        if (known) begin
            restart_operation();
        end
    endfunction

    // Expand one source byte into its pixel writes and advance the row position.
    function automatic void expand_byte(input logic [7:0] src);
        logic [8:0]   end_eff;
        logic [5:0]   last_idx;
        logic [2:0]   size;
        logic [31:0]  colour_bytes;
        logic [7:0]   bits;
        logic [7:0]   rest;
        logic [31:0]  bit_pos;
        logic         row_end;
        logic         op_end;
        int           rows;
        int           sz;
        t_pixel_write wr;
        end_eff = reg_end_bit;
        if (int'(reg_end_bit) > MAX_ROW_BITS - 1) begin
            end_eff = 9'(MAX_ROW_BITS - 1);
        end
        last_idx = end_eff[8:3];
        if (reg_pixel_bytes == 3'd0) begin
            size = 3'd1;
        end else if (reg_pixel_bytes > 3'd4) begin
            size = 3'd4;
        end else begin
            size = reg_pixel_bytes;
        end
        // Sizes below four store the low colour bytes most significant first.
        sz = int'(size);
        colour_bytes = '0;
        if (sz == 4) begin
            colour_bytes = reg_fill_colour;
        end else begin
            for (int j = 0; j < sz; j++) begin
                colour_bytes[8*j +: 8] = reg_fill_colour[8*(sz-1-j) +: 8];
            end
        end
        rows = (reg_row_count == 12'd0) ? 1 : int'(reg_row_count);

        if (row_pos > last_idx) begin
            row_pos = '0;
        end
        bits = src;
        if (row_pos == 6'd0) begin
            bits = bits & (8'hFF >> reg_first_bit);
        end
        if (row_pos == last_idx) begin
            bits = bits & ~(8'hFF >> end_eff[2:0]);
        end
        row_end = (row_pos == last_idx);
        op_end  = row_end && (int'(rows_done) + 1 >= rows);

        for (int x = 0; x < 8; x++) begin
            if (bits[7-x]) begin
                rest         = bits << (x + 1);
                bit_pos      = {26'd0, row_pos} * 32'd8 + 32'(x);
                wr.addr      = row_start + bit_pos * {29'd0, size};
                wr.data      = colour_bytes;
                wr.count     = size;
                wr.last_flag = (rest == 8'h00);
                wr.done      = op_end;
                pending_writes.push_back(wr);
            end
        end

        if (row_end) begin
            row_pos = '0;
            if (op_end) begin
                restart_operation();
            end else begin
                rows_done = rows_done + 12'd1;
                row_start = row_start + reg_dest_stride;
            end
        end else begin
            row_pos = row_pos + 6'd1;
        end
    endfunction

    // Send one source byte, with an optional idle burst in front of it.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (!quiet && input_gap_odds > 0 && $urandom_range(0, input_gap_odds - 1) == 0) begin
            gap = $urandom_range(1, 12);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_bitmap_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        expand_byte(b);
        bytes_sent++;
    endtask

    // Write one configuration register.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, value);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Stop sending, wait for every expected write, then let empty bytes drain.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_writes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reset values: one-byte rows of seven pixels, colour zero, size one.
    task automatic test_reset_defaults();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
    endtask

    // Every pixel size code, including the folded ones, near the top of memory.
    task automatic test_pixel_sizes();
        settle();
        cfg_write(CFG_FILL_COLOUR, 32'hA1B2_C3D4);
        cfg_write(CFG_DEST_BASE, 32'hFFFF_FFF8);
        for (int p = 0; p < 8; p++) begin
            settle();
            cfg_write(CFG_PIXEL_BYTES, 32'(p));
            send_byte(8'hFE);
        end
    endtask

    // Start and end masks, including an end bit on a byte boundary.
    task automatic test_row_masks();
        settle();
        cfg_write(CFG_PIXEL_BYTES, 32'd1);
        cfg_write(CFG_DEST_BASE, 32'd0);
        cfg_write(CFG_FIRST_BIT, 32'd7);
        cfg_write(CFG_END_BIT, 32'd16);
        send_byte(8'hFF);
        send_byte(8'hFF);
        send_byte(8'hFF);
        settle();
        cfg_write(CFG_FIRST_BIT, 32'd3);
        cfg_write(CFG_END_BIT, 32'd15);
        send_byte(8'hFF);
        send_byte(8'hFF);
        settle();
        cfg_write(CFG_END_BIT, 32'd0);
        send_byte(8'hFF);
    endtask

    // Row stepping, zero row count and a write to an unused register index.
    task automatic test_row_stepping();
        settle();
        cfg_write(CFG_END_BIT, 32'd7);
        cfg_write(CFG_FIRST_BIT, 32'd0);
        cfg_write(CFG_DEST_BASE, 32'd1000);
        cfg_write(CFG_DEST_STRIDE, 32'hFFFF_FF9C);
        cfg_write(CFG_ROW_COUNT, 32'd3);
        repeat (4) send_byte(8'h80);
        settle();
        cfg_write(CFG_ROW_COUNT, 32'd0);
        send_byte(8'h80);
        send_byte(8'h41);
        settle();
        cfg_write(CFG_ROW_COUNT, 32'd2);
        cfg_write(CFG_DEST_STRIDE, 32'h7FFF_FFFF);
        send_byte(8'h80);
        settle();
        cfg_write(CFG_IDX_SPARE, 32'hFFFF_FFFF);
        send_byte(8'h80);
    endtask

    function automatic logic [7:0] random_bitmap();
        logic [7:0] b;
        case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = 8'h01 << $urandom_range(0, 7);
            default: b = 8'($urandom);
        endcase
        return b;
    endfunction

    // Rewrite a random subset of the registers, leaning on the extremes.
    task automatic randomize_registers();
        logic [31:0] rnd;
        logic [31:0] val;
        rnd = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0:       val = 32'd0;
                1:       val = 32'hFFFF_FFFF;
                2:       val = 32'hFFFF_FF00 + $urandom_range(0, 255);
                default: val = $urandom;
            endcase
            cfg_write(CFG_DEST_BASE, val);
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 4))
                0:       val = 32'h8000_0000;
                1:       val = 32'h7FFF_FFFF;
                2:       val = 32'd0;
                3:       val = 32'($urandom_range(0, 600)) - 32'd300;
                default: val = $urandom;
            endcase
            cfg_write(CFG_DEST_STRIDE, val);
        end
        if ($urandom_range(0, 1) == 0) begin
            cfg_write(CFG_FIRST_BIT, {rnd[31:3], 3'($urandom_range(0, 7))});
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 9))
                0:       val = 32'd511;
                1:       val = 32'($urandom_range(24, 63));
                2:       val = 32'($urandom_range(0, 511));
                default: val = 32'($urandom_range(0, 23));
            endcase
            cfg_write(CFG_END_BIT, {rnd[31:9], val[8:0]});
        end
        if ($urandom_range(0, 1) == 0) begin
            cfg_write(CFG_PIXEL_BYTES, {rnd[31:3], 3'($urandom_range(0, 7))});
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 3))
                0:       val = 32'd0;
                1:       val = 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase
            cfg_write(CFG_FILL_COLOUR, val);
        end
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 9))
                0:       val = 32'd0;
                1:       val = 32'd4095;
                2:       val = 32'($urandom_range(0, 4095));
                default: val = 32'($urandom_range(1, 4));
            endcase
            cfg_write(CFG_ROW_COUNT, {rnd[31:12], val[11:0]});
        end
    endtask

    // Mostly whole operations with random content, some cut short.
    task automatic test_random_operations();
        int sent;
        int phase_len;
        int rows;
        int row_bytes;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - QUIET_ITEMS) begin
                quiet = 1'b1;
            end
            settle();
            randomize_registers();
            case ($urandom_range(0, 2))
                0:       input_gap_odds = 0;
                1:       input_gap_odds = 8;
                default: input_gap_odds = 3;
            endcase
            row_bytes = int'(reg_end_bit >> 3) + 1;
            rows      = (reg_row_count == 12'd0) ? 1 : int'(reg_row_count);
            if ($urandom_range(0, 4) == 0) begin
                phase_len = $urandom_range(1, 2 * row_bytes);
            end else begin
                phase_len = row_bytes * rows * $urandom_range(1, 2);
                if (phase_len > 70) begin
                    phase_len = row_bytes * ((70 / row_bytes) > 0 ? (70 / row_bytes) : 1);
                end
            end
            for (int k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                send_byte(random_bitmap());
                sent++;
            end
        end
    endtask

    // Output side: random stall bursts, none once the run goes quiet.
    initial begin : drive_out_ready
        int n;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!quiet && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 12);
                i_out_ready <= 1'b0;
            end else begin
                n = $urandom_range(1, 16);
                i_out_ready <= 1'b1;
            end
            repeat (n - 1) @(negedge i_clk);
        end
    end

    // Compare each output transaction with the oldest expected write.
    always @(posedge i_clk) begin : check_writes
        t_pixel_write want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            writes_seen++;
            if (pending_writes.size() == 0) begin
                report_mismatch($sformatf("unexpected write addr %h data %h",
                                          o_write_address, o_write_data));
            end else begin
                want = pending_writes.pop_front();
                if (o_write_address !== want.addr) begin
                    report_mismatch($sformatf("address %h, expected %h",
                                              o_write_address, want.addr));
                end
                if (o_write_data !== want.data) begin
                    report_mismatch($sformatf("data %h, expected %h at %h",
                                              o_write_data, want.data, want.addr));
                end
                if (o_write_count !== want.count) begin
                    report_mismatch($sformatf("count %0d, expected %0d at %h",
                                              o_write_count, want.count, want.addr));
                end
                if (o_last_of_byte !== want.last_flag) begin
                    report_mismatch($sformatf("last_of_byte %b, expected %b at %h",
                                              o_last_of_byte, want.last_flag, want.addr));
                end
                if (o_operation_done !== want.done) begin
                    report_mismatch($sformatf("operation_done %b, expected %b at %h",
                                              o_operation_done, want.done, want.addr));
                end
            end
        end
    end

    // Test sequence.
    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_bitmap_byte  = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        quiet          = 1'b0;
        input_gap_odds = 4;
        error_count    = 0;
        bytes_sent     = 0;
        writes_seen    = 0;
        cfg_writes     = 0;
        cycle_count    = 0;
        reset_registers();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_pixel_sizes();
        test_row_masks();
        test_row_stepping();
        test_random_operations();
        settle();

        $display("Covered %0d source bytes, %0d pixel writes and %0d register writes,",
                 bytes_sent, writes_seen, cfg_writes);
        $display("over all pixel size codes, masked row edges and rows of up to 64 bytes.");
        if (error_count == 0) begin
            $display("tb_mono_bitmap_colour_expand OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("tb_mono_bitmap_colour_expand NOT OK");
        end
        $finish;
    end

endmodule

// ----- mono_bitmap_colour_expand.f -----
+incdir+rtl
rtl/mbce_pkg.sv
rtl/mbce_front.sv
rtl/mbce_fifo.sv
rtl/mbce_back.sv
rtl/mono_bitmap_colour_expand.sv
bench/tb_mono_bitmap_colour_expand.sv
